// ===== hdl/utc_pkg.sv =====
`default_nettype none
package utc_pkg;

    localparam int UNIT_W = 16;
    localparam int BYTE_W = 8;

    typedef logic [UNIT_W-1:0] t_unit;
    typedef logic [BYTE_W-1:0] t_byte;

    localparam t_unit CAP_RESET = 16'd4096;

endpackage
`default_nettype wire

// ===== hdl/utc_unit_if.sv =====
`default_nettype none
interface utc_unit_if;
    logic           valid;
    logic           ready;
    utc_pkg::t_unit code_unit;

    modport source (output valid, output code_unit, input ready);
    modport sink   (input valid, input code_unit, output ready);
endinterface
`default_nettype wire

// ===== hdl/utc_byte_if.sv =====
`default_nettype none
interface utc_byte_if;
    logic           valid;
    logic           ready;
    utc_pkg::t_byte out_byte;
    logic           is_last;

    modport source (output valid, output out_byte, output is_last, input ready);
    modport sink   (input valid, input out_byte, input is_last, output ready);
endinterface
`default_nettype wire

// ===== hdl/utf16_to_utf8_converter_unit.sv =====
// Channel   Direction  Payload                    Words per unit
// i_unit    in         code_unit[15:0]            1
// o_byte    out        out_byte[7:0], is_last     0 to 6
// cfg       in         i_cfg_wr_data[15:0]        capacity register
//
// A unit sits in the input register, is encoded combinationally into a
// six-byte result buffer, and the buffer drains one byte per cycle while
// o_byte.ready is high; the byte-wide output port sets the rate.
// Reset (synchronous, active low) empties both stages and clears the state.
// Output stalls back up into the input register, then into i_unit.ready.
`default_nettype none
module utf16_to_utf8_converter_unit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_wr_en,
    input  wire utc_pkg::t_unit i_cfg_wr_data,
    utc_unit_if.sink            i_unit,
    utc_byte_if.source          o_byte
);

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      len;
    } t_enc;

    function automatic t_enc f_encode(input logic [20:0] c);
        t_enc e;
        e = '0;
        if (c < 21'h80) begin
            e.b[0] = c[7:0];
            e.len  = 3'd1;
        end else if (c < 21'h800) begin
            e.b[0] = {3'b110, c[10:6]};
            e.b[1] = {2'b10, c[5:0]};
            e.len  = 3'd2;
        end else if (c < 21'h10000) begin
            e.b[0] = {4'b1110, c[15:12]};
            e.b[1] = {2'b10, c[11:6]};
            e.b[2] = {2'b10, c[5:0]};
            e.len  = 3'd3;
        end else begin
            e.b[0] = {5'b11110, c[20:18]};
            e.b[1] = {2'b10, c[17:12]};
            e.b[2] = {2'b10, c[11:6]};
            e.b[3] = {2'b10, c[5:0]};
            e.len  = 3'd4;
        end
        return e;
    endfunction

    utc_pkg::t_unit  r_cap;
    logic            r_in_valid;
    utc_pkg::t_unit  r_in_unit;
    logic [5:0][7:0] r_bytes, n_bytes;
    logic [2:0]      r_left, n_cnt;
    logic            r_term, n_term;
    utc_pkg::t_unit  r_held, n_held;
    logic            r_held_valid, n_held_valid;
    utc_pkg::t_unit  r_bw, n_bw;
    logic            r_trunc, n_trunc;

    logic           res_free;
    logic           proc;
    logic           pop;
    logic           is_low, is_high;
    t_enc           enc_held, enc_u, enc_pair;
    utc_pkg::t_unit bw_base;
    logic           fits;

    assign pop      = (r_left != 3'd0) && o_byte.ready;
    assign res_free = (r_left == 3'd0) || ((r_left == 3'd1) && o_byte.ready);
    assign proc     = r_in_valid && res_free;

    assign i_unit.ready    = !r_in_valid || proc;
    assign o_byte.valid    = (r_left != 3'd0);
    assign o_byte.out_byte = r_bytes[0];
    assign o_byte.is_last  = r_term && (r_left == 3'd1);

    assign is_low   = (r_in_unit[15:10] == 6'b110111);
    assign is_high  = (r_in_unit[15:10] == 6'b110110);
    assign enc_held = f_encode({5'b0, r_held});
    assign enc_u    = f_encode({5'b0, r_in_unit});
    assign enc_pair = f_encode(21'h10000 + {1'b0, r_held[9:0], r_in_unit[9:0]});
    assign bw_base  = r_held_valid ? (r_bw + 16'd3) : r_bw;
    assign fits     = ({1'b0, bw_base} + 17'd5) < {1'b0, r_cap};

    always_comb begin
        n_bytes      = '0;
        n_cnt        = 3'd0;
        n_term       = 1'b0;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_bw         = r_bw;
        n_trunc      = r_trunc;
        if (r_in_unit == '0) begin
            if (r_held_valid && !r_trunc) begin
                n_bytes[2:0] = enc_held.b[2:0];
                n_cnt        = 3'd4;
            end else begin
                n_cnt = 3'd1;
            end
            n_term       = 1'b1;
            n_held       = '0;
            n_held_valid = 1'b0;
            n_bw         = '0;
            n_trunc      = 1'b0;
        end else if (!r_trunc) begin
            if (r_held_valid && is_low) begin
                n_bytes[3:0] = enc_pair.b;
                n_cnt        = 3'd4;
                n_bw         = r_bw + 16'd4;
                n_held       = '0;
                n_held_valid = 1'b0;
            end else begin
                if (r_held_valid) begin
                    n_bytes[2:0] = enc_held.b[2:0];
                    n_cnt        = 3'd3;
                    n_held       = '0;
                    n_held_valid = 1'b0;
                end
                n_bw = bw_base;
                if (!fits) begin
                    n_trunc = 1'b1;
                end else if (is_high) begin
                    n_held       = r_in_unit;
                    n_held_valid = 1'b1;
                end else begin
                    if (r_held_valid) begin
                        n_bytes[5:3] = enc_u.b[2:0];
                    end else begin
                        n_bytes[2:0] = enc_u.b[2:0];
                    end
                    n_cnt = n_cnt + enc_u.len;
                    n_bw  = bw_base + {13'b0, enc_u.len};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap        <= utc_pkg::CAP_RESET;
            r_in_valid   <= 1'b0;
            r_left       <= 3'd0;
            r_term       <= 1'b0;
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_bw         <= '0;
            r_trunc      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (i_unit.valid && i_unit.ready) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_left       <= n_cnt;
                r_term       <= n_term;
                r_held       <= n_held;
                r_held_valid <= n_held_valid;
                r_bw         <= n_bw;
                r_trunc      <= n_trunc;
            end else if (pop) begin
                r_left <= r_left - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_unit.valid && i_unit.ready) begin
            r_in_unit <= i_unit.code_unit;
        end
        if (proc) begin
            r_bytes <= n_bytes;
        end else if (pop) begin
            r_bytes <= r_bytes >> 8;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/utc_checker.sv =====
`default_nettype none
module utc_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           i_in_ready,
    input wire logic           i_out_valid,
    input wire logic           i_out_ready,
    input wire utc_pkg::t_byte i_out_byte,
    input wire logic           i_out_last
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("output not empty after reset");

    a_last_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_last |-> i_out_byte == 8'h00)
        else $error("terminator word is not zero");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with nothing to deliver");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_out_last))
        else $error("stalled output word changed");

endmodule

bind utf16_to_utf8_converter_unit utc_checker u_utc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_unit.valid),
    .i_in_ready  (i_unit.ready),
    .i_out_valid (o_byte.valid),
    .i_out_ready (o_byte.ready),
    .i_out_byte  (o_byte.out_byte),
    .i_out_last  (o_byte.is_last)
);
`default_nettype wire

// ===== sim/utf16_to_utf8_converter_unit_test.sv =====
`timescale 1ns / 100ps

module utf16_to_utf8_converter_unit_test;

    typedef utc_pkg::t_unit t_unit;
    typedef utc_pkg::t_byte t_byte;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned HOLD_CYCLES = 150;

    localparam t_unit HIGH_FIRST = 16'hD800;
    localparam t_unit HIGH_LAST  = 16'hDBFF;
    localparam t_unit LOW_FIRST  = 16'hDC00;
    localparam t_unit LOW_LAST   = 16'hDFFF;
    localparam t_unit TERMINATOR = 16'h0000;

    typedef struct packed {
        t_byte data;
        logic  last;
    } t_utf8_word;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_wr_en;
    t_unit i_cfg_wr_data;

    utc_unit_if unit_if ();
    utc_byte_if byte_if ();

    utf16_to_utf8_converter_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_unit        (unit_if),
        .o_byte        (byte_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // transcoder state as predicted
    t_unit       capacity;
    t_unit       held_unit;
    bit          held_ok;
    logic [15:0] bytes_out;
    bit          cut_off;

    t_utf8_word  utf8_expected[$];
    t_unit       pending_units[$];

    int unsigned units_queued;
    int unsigned units_accepted;
    int unsigned bytes_checked;
    int unsigned strings_closed;
    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned hold_left;
    bit          hold_done;
    bit          unit_taken;

    task automatic push_byte(input t_byte b, input logic last);
        t_utf8_word w;
        w.data = b;
        w.last = last;
        utf8_expected.push_back(w);
    endtask

    task automatic encode_char(input int unsigned c);
        if (c < 32'h80) begin
            push_byte(t_byte'(c), 1'b0);
            bytes_out += 16'd1;
        end else if (c < 32'h800) begin
            push_byte(8'hC0 | t_byte'(c >> 6), 1'b0);
            push_byte(8'h80 | t_byte'(c & 32'h3F), 1'b0);
            bytes_out += 16'd2;
        end else if (c < 32'h10000) begin
            push_byte(8'hE0 | t_byte'(c >> 12), 1'b0);
            push_byte(8'h80 | t_byte'((c >> 6) & 32'h3F), 1'b0);
            push_byte(8'h80 | t_byte'(c & 32'h3F), 1'b0);
            bytes_out += 16'd3;
        end else begin
            push_byte(8'hF0 | t_byte'(c >> 18), 1'b0);
            push_byte(8'h80 | t_byte'((c >> 12) & 32'h3F), 1'b0);
            push_byte(8'h80 | t_byte'((c >> 6) & 32'h3F), 1'b0);
            push_byte(8'h80 | t_byte'(c & 32'h3F), 1'b0);
            bytes_out += 16'd4;
        end
    endtask

    task automatic predict_unit(input t_unit u);
        if (u == TERMINATOR) begin
            if (held_ok && !cut_off)
                encode_char(32'(held_unit));
            push_byte(8'h00, 1'b1);
            held_unit = '0;
            held_ok   = 1'b0;
            bytes_out = '0;
            cut_off   = 1'b0;
            return;
        end
        if (cut_off)
            return;
        if (held_ok) begin
            held_ok = 1'b0;
            if (u >= LOW_FIRST && u <= LOW_LAST) begin
                encode_char(32'h10000 + ((32'(held_unit) - 32'(HIGH_FIRST)) << 10)
                            + (32'(u) - 32'(LOW_FIRST)));
                held_unit = '0;
                return;
            end
            encode_char(32'(held_unit));
            held_unit = '0;
        end
        if (32'(bytes_out) + 32'd5 >= 32'(capacity)) begin
            cut_off = 1'b1;
            return;
        end
        if (u >= HIGH_FIRST && u <= HIGH_LAST) begin
            held_unit = u;
            held_ok   = 1'b1;
            return;
        end
        encode_char(32'(u));
    endtask

    task automatic queue_unit(input t_unit u);
        pending_units.push_back(u);
        units_queued++;
    endtask

    // mostly well-formed text with random content, some lone surrogates and noise
    task automatic queue_string(input int unsigned n_chars);
        int unsigned kind;
        int unsigned cp;
        repeat (n_chars) begin
            kind = $urandom_range(99);
            if (kind < 20) begin
                queue_unit(t_unit'($urandom_range(1, 32'h7F)));
            end else if (kind < 35) begin
                queue_unit(t_unit'($urandom_range(32'h80, 32'h7FF)));
            end else if (kind < 55) begin
                cp = $urandom_range(32'h800, 32'hF7FF);
                if (cp >= 32'hD800)
                    cp += 32'h800;
                queue_unit(t_unit'(cp));
            end else if (kind < 80) begin
                cp = $urandom_range(0, 32'hFFFFF);
                queue_unit(HIGH_FIRST | t_unit'(cp >> 10));
                queue_unit(LOW_FIRST | t_unit'(cp & 32'h3FF));
            end else if (kind < 87) begin
                queue_unit(t_unit'($urandom_range(HIGH_FIRST, HIGH_LAST)));
            end else if (kind < 92) begin
                queue_unit(t_unit'($urandom_range(LOW_FIRST, LOW_LAST)));
            end else begin
                queue_unit(t_unit'($urandom_range(1, 32'hFFFF)));
            end
        end
        queue_unit(TERMINATOR);
    endtask

    task automatic write_capacity(input t_unit value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        capacity = value;
    endtask

    task automatic drain;
        wait (units_accepted == units_queued && utf8_expected.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            unit_if.valid <= 1'b0;
        end else if (!unit_if.valid || unit_taken) begin
            if (pending_units.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                unit_if.valid     <= 1'b1;
                unit_if.code_unit <= pending_units.pop_front();
            end else begin
                unit_if.valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (!i_rst_n)
            byte_if.ready <= 1'b0;
        else
            byte_if.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end

    // long receiver hold-off while the sender keeps offering
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && tx_idle_pct == 0 && pending_units.size() > 40) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_utf8_word want;
        unit_taken = 1'b0;
        if (i_rst_n) begin
            if (unit_if.valid && unit_if.ready) begin
                unit_taken = 1'b1;
                units_accepted++;
                predict_unit(unit_if.code_unit);
            end
            if (byte_if.valid && byte_if.ready) begin
                bytes_checked++;
                if (byte_if.is_last)
                    strings_closed++;
                if (utf8_expected.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word out_byte=%02h is_last=%0b", $time,
                             byte_if.out_byte, byte_if.is_last);
                end else begin
                    want = utf8_expected.pop_front();
                    if (byte_if.out_byte !== want.data) begin
                        mismatches++;
                        $display("%0t: out_byte expected %02h, actual %02h", $time,
                                 want.data, byte_if.out_byte);
                    end
                    if (byte_if.is_last !== want.last) begin
                        mismatches++;
                        $display("%0t: is_last expected %0b, actual %0b", $time,
                                 want.last, byte_if.is_last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timed out, %0d words still expected", $time,
                     utf8_expected.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int unsigned mark;
        i_rst_n           = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_wr_data     = '0;
        unit_if.valid     = 1'b0;
        unit_if.code_unit = '0;
        byte_if.ready     = 1'b0;
        capacity          = utc_pkg::CAP_RESET;
        held_unit         = '0;
        held_ok           = 1'b0;
        bytes_out         = '0;
        cut_off           = 1'b0;
        units_queued      = 0;
        units_accepted    = 0;
        bytes_checked     = 0;
        strings_closed    = 0;
        mismatches        = 0;
        cycle_count       = 0;
        hold_left         = 0;
        hold_done         = 1'b0;
        unit_taken        = 1'b0;
        tx_idle_pct       = 14;
        rx_idle_pct       = 88;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset capacity
        queue_unit(TERMINATOR);
        queue_unit(16'h0041);
        queue_unit(16'h007F);
        queue_unit(16'h0080);
        queue_unit(16'h07FF);
        queue_unit(16'h0800);
        queue_unit(16'hFFFF);
        queue_unit(HIGH_FIRST);
        queue_unit(LOW_FIRST);
        queue_unit(HIGH_LAST);
        queue_unit(LOW_LAST);
        queue_unit(LOW_FIRST);
        queue_unit(16'hD801);
        queue_unit(16'h0041);
        queue_unit(16'hD802);
        queue_unit(16'hD803);
        queue_unit(16'hE000);
        queue_unit(16'hD804);
        queue_unit(TERMINATOR);
        drain();

        // tiny capacities: nothing fits below 6
        write_capacity(16'd1);
        queue_unit(16'h0041);
        queue_unit(HIGH_FIRST);
        queue_unit(LOW_FIRST);
        queue_unit(TERMINATOR);
        drain();
        write_capacity(16'd5);
        queue_unit(16'h0041);
        queue_unit(TERMINATOR);
        drain();
        write_capacity(16'd6);
        queue_unit(16'h0041);
        queue_unit(16'h0042);
        queue_unit(TERMINATOR);
        queue_unit(HIGH_FIRST);
        queue_unit(LOW_LAST);
        queue_unit(TERMINATOR);
        queue_unit(16'hD9AB);
        queue_unit(16'h0041);
        queue_unit(16'h0042);
        queue_unit(TERMINATOR);
        drain();

        // random, short buffer
        tx_idle_pct = 88;
        rx_idle_pct = 14;
        write_capacity(16'd20);
        mark = units_queued;
        while (units_queued - mark < 40)
            queue_string($urandom_range(3, 12));
        drain();

        write_capacity(16'hFFFF);
        mark = units_queued;
        while (units_queued - mark < 80)
            queue_string($urandom_range(1, 12));
        drain();

        // no idling, with the long hold-off
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_capacity(t_unit'($urandom_range(7, 40)));
        mark = units_queued;
        while (units_queued - mark < 90)
            queue_string($urandom_range(2, 14));
        drain();

        $display("%0d code units, %0d strings, %0d UTF-8 bytes checked", units_accepted,
                 strings_closed, bytes_checked);
        $display("capacities from 1 to 65535, surrogate pairs, lone surrogates, truncation");
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
